// ===== rtl/core/rbbo_pkg.sv =====
// Package: types, sine table and fixed-point helpers for the beam/box overlap block.
`timescale 1ns / 1ps
package rbbo_pkg;

   localparam int PHASE_BITS = 16;
   localparam int COORD_W    = 16;
   localparam int SIZE_W     = 15;
   localparam int TRIG_W     = 17;   // signed Q1.15, range -32767..32767
   localparam int HALF_W     = 19;   // 2*(dx) +- size, signed
   localparam int PROD_W     = HALF_W + TRIG_W;   // one product
   localparam int ROT_W      = PROD_W + 1;        // sum of two products
   localparam int AX_W       = ROT_W + 3;         // axis test sums

   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [HALF_W-1:0] half_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ROT_W-1:0]  rot_type;
   typedef logic signed [AX_W-1:0]   ax_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] beam_x;
      logic signed [COORD_W-1:0] beam_y;
      logic [SIZE_W-1:0]         beam_width;
      logic [SIZE_W-1:0]         beam_length;
      logic [PHASE_BITS-1:0]     beam_phase;
      logic signed [COORD_W-1:0] box_x;
      logic signed [COORD_W-1:0] box_y;
      logic [SIZE_W-1:0]         box_width;
      logic [SIZE_W-1:0]         box_height;
   } req_type;

   function automatic logic [15:0] qsine(input logic [4:0] k);
      case (k)
         5'd0:  qsine = 16'd0;
         5'd1:  qsine = 16'd3212;
         5'd2:  qsine = 16'd6393;
         5'd3:  qsine = 16'd9512;
         5'd4:  qsine = 16'd12540;
         5'd5:  qsine = 16'd15447;
         5'd6:  qsine = 16'd18205;
         5'd7:  qsine = 16'd20788;
         5'd8:  qsine = 16'd23170;
         5'd9:  qsine = 16'd25330;
         5'd10: qsine = 16'd27246;
         5'd11: qsine = 16'd28899;
         5'd12: qsine = 16'd30274;
         5'd13: qsine = 16'd31357;
         5'd14: qsine = 16'd32138;
         5'd15: qsine = 16'd32610;
         default: qsine = 16'd32767;
      endcase
   endfunction

   // Q1.15 sine of a 16-bit phase, linear interpolation, round half up.
   function automatic trig_type sine16(input logic [15:0] p);
      logic [13:0] off;
      logic [14:0] o;
      logic [4:0]  idx;
      logic [9:0]  fr;
      logic [15:0] lo;
      logic [15:0] hi;
      logic [25:0] pr;
      logic [15:0] mag;
      off = p[13:0];
      o   = p[14] ? (15'd16384 - {1'b0, off}) : {1'b0, off};
      idx = o[14:10];
      fr  = o[9:0];
      lo  = qsine(idx);
      hi  = qsine(idx + 5'd1);
      pr  = 26'(hi - lo) * 26'(fr) + 26'd512;
      mag = (idx >= 5'd16) ? 16'd32767 : lo + pr[25:10];
      sine16 = p[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   function automatic ax_type absx(input ax_type v);
      absx = v[AX_W-1] ? -v : v;
   endfunction

   // |mn+mx+off| < (mx-mn) + size
   function automatic logic axis_ok(input rot_type a, input rot_type b,
                                    input rot_type c, input rot_type d,
                                    input ax_type off, input ax_type size);
      rot_type mn;
      rot_type mx;
      ax_type  s;
      mn = a; mx = a;
      if (b < mn) mn = b;
      if (b > mx) mx = b;
      if (c < mn) mn = c;
      if (c > mx) mx = c;
      if (d < mn) mn = d;
      if (d > mx) mx = d;
      s = AX_W'(mn) + AX_W'(mx) + off;
      axis_ok = absx(s) < (AX_W'(mx) - AX_W'(mn) + size);
   endfunction

endpackage

// ===== rtl/core/rbbo_front.sv =====
// Front stages: trig lookup and corner offsets, two register levels.
`timescale 1ns / 1ps
module rbbo_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  rbbo_pkg::req_type    in_req,
   output logic                 out_valid,
   output rbbo_pkg::trig_type   out_s,
   output rbbo_pkg::trig_type   out_c,
   output rbbo_pkg::half_type   out_hx [4],
   output rbbo_pkg::half_type   out_hy [4],
   output rbbo_pkg::req_type    out_req
);
   logic              v1_ff, v2_ff;
   logic [15:0]       t_ff;
   rbbo_pkg::req_type r1_ff, r2_ff;
   rbbo_pkg::trig_type s_ff, c_ff;
   rbbo_pkg::half_type hx_ff [4];
   rbbo_pkg::half_type hy_ff [4];
   rbbo_pkg::half_type dxo, dyo;

   assign dxo = (rbbo_pkg::HALF_W'(r1_ff.box_x) - rbbo_pkg::HALF_W'(r1_ff.beam_x)) <<< 1;
   assign dyo = (rbbo_pkg::HALF_W'(r1_ff.box_y) - rbbo_pkg::HALF_W'(r1_ff.beam_y)) <<< 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff <= in_req;
         t_ff  <= in_req.beam_phase - 16'd16384;
         r2_ff <= r1_ff;
         s_ff  <= rbbo_pkg::sine16(t_ff);
         c_ff  <= rbbo_pkg::sine16(t_ff + 16'd16384);
         // beam corners (pass one) in lanes 0..1, box corners (pass two) in 2..3
         hx_ff[0] <= -rbbo_pkg::HALF_W'(r1_ff.beam_width);
         hx_ff[1] <=  rbbo_pkg::HALF_W'(r1_ff.beam_width);
         hy_ff[0] <= '0;
         hy_ff[1] <=  rbbo_pkg::HALF_W'(r1_ff.beam_length) <<< 1;
         hx_ff[2] <= dxo - rbbo_pkg::HALF_W'(r1_ff.box_width);
         hx_ff[3] <= dxo + rbbo_pkg::HALF_W'(r1_ff.box_width);
         hy_ff[2] <= dyo - rbbo_pkg::HALF_W'(r1_ff.box_height);
         hy_ff[3] <= dyo + rbbo_pkg::HALF_W'(r1_ff.box_height);
      end
   end

   assign out_valid = v2_ff;
   assign out_s = s_ff;
   assign out_c = c_ff;
   assign out_hx = hx_ff;
   assign out_hy = hy_ff;
   assign out_req = r2_ff;
endmodule

// ===== rtl/core/rbbo_back.sv =====
// Back stages: products, rotated sums, then the four axis tests.
`timescale 1ns / 1ps
module rbbo_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  rbbo_pkg::trig_type   in_s,
   input  rbbo_pkg::trig_type   in_c,
   input  rbbo_pkg::half_type   in_hx [4],
   input  rbbo_pkg::half_type   in_hy [4],
   input  rbbo_pkg::req_type    in_req,
   output logic                 out_valid,
   output logic                 out_hit
);
   logic v3_ff, v4_ff, v5_ff, hit_ff;
   rbbo_pkg::prod_type xc_ff [4], xs_ff [4], yc_ff [4], ys_ff [4];
   rbbo_pkg::rot_type  ra_ff [4][4];   // [pass-corner][xs1,ys1,xs2,ys2]
   rbbo_pkg::req_type  r3_ff, r4_ff;
   rbbo_pkg::ax_type   o1x, o1y, sw, sh, sbw, sbl;
   logic               p1x, p1y, p2x, p2y;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= in_valid; v4_ff <= v3_ff; v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r3_ff <= in_req;
         r4_ff <= r3_ff;
         for (int i = 0; i < 4; i++) begin
            xc_ff[i] <= in_hx[i] * in_c;
            xs_ff[i] <= in_hx[i] * in_s;
            yc_ff[i] <= in_hy[i] * in_c;
            ys_ff[i] <= in_hy[i] * in_s;
         end
         for (int i = 0; i < 4; i++) begin
            // i: corner, x lane i[0], y lane i[1]
            ra_ff[i][0] <= rbbo_pkg::ROT_W'(xc_ff[i[0]])   - rbbo_pkg::ROT_W'(ys_ff[i[1]]);
            ra_ff[i][1] <= rbbo_pkg::ROT_W'(xs_ff[i[0]])   + rbbo_pkg::ROT_W'(yc_ff[i[1]]);
            ra_ff[i][2] <= rbbo_pkg::ROT_W'(xc_ff[2+i[0]]) + rbbo_pkg::ROT_W'(ys_ff[2+i[1]]);
            ra_ff[i][3] <= rbbo_pkg::ROT_W'(yc_ff[2+i[1]]) - rbbo_pkg::ROT_W'(xs_ff[2+i[0]]);
         end
         hit_ff <= p1x && p1y && p2x && p2y;
      end
   end

   assign o1x = (rbbo_pkg::AX_W'(r4_ff.beam_x) - rbbo_pkg::AX_W'(r4_ff.box_x)) <<< 17;
   assign o1y = (rbbo_pkg::AX_W'(r4_ff.beam_y) - rbbo_pkg::AX_W'(r4_ff.box_y)) <<< 17;
   assign sw  = rbbo_pkg::AX_W'(r4_ff.box_width) <<< 16;
   assign sh  = rbbo_pkg::AX_W'(r4_ff.box_height) <<< 16;
   assign sbw = rbbo_pkg::AX_W'(r4_ff.beam_width) <<< 16;
   assign sbl = rbbo_pkg::AX_W'(r4_ff.beam_length) <<< 16;

   assign p1x = rbbo_pkg::axis_ok(ra_ff[0][0], ra_ff[1][0], ra_ff[2][0], ra_ff[3][0], o1x, sw);
   assign p1y = rbbo_pkg::axis_ok(ra_ff[0][1], ra_ff[1][1], ra_ff[2][1], ra_ff[3][1], o1y, sh);
   assign p2x = rbbo_pkg::axis_ok(ra_ff[0][2], ra_ff[1][2], ra_ff[2][2], ra_ff[3][2],
                                  '0, sbw);
   assign p2y = rbbo_pkg::axis_ok(ra_ff[0][3], ra_ff[1][3], ra_ff[2][3], ra_ff[3][3],
                                  -sbl, sbl);

   assign out_valid = v5_ff;
   assign out_hit = hit_ff;

   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      en |=> (v4_ff == $past(v3_ff))) else $error("valid lost in back stages");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(hit_ff) && $stable(v5_ff)) else $error("stage moved during stall");
   a_r4: assert property (@(posedge clock) disable iff (reset)
      en |=> r4_ff === $past(r3_ff)) else $error("request lost");
endmodule

// ===== rtl/core/rotated_beam_box_overlap.sv =====
// Top level: rotated beam versus centred box overlap, streaming in and out.
//
//  channel  dir  tdata (low bit up)                                        tuser tlast
//  req_     in   beam_x16 beam_y16 beam_width15 beam_length15 beam_phase16
//                box_x16 box_y16 box_width15 box_height15, pad to 144      -     -
//  rsp_     out  hit1, pad to 8                                            -     -
//
// Fully pipelined: one request per cycle while rsp_ is not stalled; five register
// stages lie between req_ and rsp_tvalid.
// Stages: phase offset, trig lookup and corner offsets, products, rotated sums,
// axis compare.
// Reset clears all valid bits; payload is not reset.
// A stall on rsp_ freezes the whole pipe; req_tready follows the pipe enable,
// which is high while the output stage is empty or being taken.
`timescale 1ns / 1ps
module rotated_beam_box_overlap (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,   // beam_x, beam_y, beam_width, beam_length,
                                     // beam_phase, box_x, box_y, box_width, box_height
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata    // hit
);
   rbbo_pkg::req_type  req;
   logic               en, fv, hit, ov;
   rbbo_pkg::trig_type s, c;
   rbbo_pkg::half_type hx [4];
   rbbo_pkg::half_type hy [4];
   rbbo_pkg::req_type  freq;

   // field unpack, first field lowest
   assign req.beam_x      = req_tdata[15:0];
   assign req.beam_y      = req_tdata[31:16];
   assign req.beam_width  = req_tdata[46:32];
   assign req.beam_length = req_tdata[61:47];
   assign req.beam_phase  = req_tdata[77:62];
   assign req.box_x       = req_tdata[93:78];
   assign req.box_y       = req_tdata[109:94];
   assign req.box_width   = req_tdata[124:110];
   assign req.box_height  = req_tdata[139:125];

   // pipe advances unless a finished result is waiting
   assign en = !ov || rsp_tready;
   assign req_tready = en;

   rbbo_front u_front (
      .clock, .reset, .en,
      .in_valid (req_tvalid && en),
      .in_req   (req),
      .out_valid(fv), .out_s(s), .out_c(c), .out_hx(hx), .out_hy(hy), .out_req(freq)
   );

   rbbo_back u_back (
      .clock, .reset, .en,
      .in_valid(fv), .in_s(s), .in_c(c), .in_hx(hx), .in_hy(hy), .in_req(freq),
      .out_valid(ov), .out_hit(hit)
   );

   assign rsp_tvalid = ov;
   assign rsp_tdata  = {7'd0, hit};
endmodule

// ===== test/tb_rotated_beam_box_overlap.sv =====
// Testbench for the rotated beam versus box overlap block: directed and random pairs.
`timescale 1ns / 1ps
module tb_rotated_beam_box_overlap;

   localparam int RANDOM_ITEMS = 950;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 20;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;   // beam_x, beam_y, beam_width, beam_length,
                              // beam_phase, box_x, box_y, box_width, box_height
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [7:0]   rsp_tdata;   // hit

   rotated_beam_box_overlap dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // One beam/box pair, unpacked.
   typedef struct {
      logic signed [15:0] bx, by;
      logic [14:0]        bw, bl;
      logic [15:0]        ph;
      logic signed [15:0] ox, oy;
      logic [14:0]        ow, oh;
   } pair_type;

   bit   hit_queue[$];   // predicted hit per accepted request
   int   errors;
   int   requests_sent;
   int   results_seen;
   int   hits_seen;
   int   idle_cycles;
   int   send_idle_pct;
   int   recv_stall_pct;
   bit   stim_done;
   bit   timed_out;

   // Directed table: expectation typed in (0/1), or -1 for "use the predictor".
   pair_type dir_pair[$];
   int       dir_hit[$];

   function automatic logic [143:0] pack_pair(input pair_type p);
      pack_pair = {4'd0, p.oh, p.ow, p.oy, p.ox, p.ph, p.bl, p.bw, p.by, p.bx};
   endfunction

   // Table sine: quarter wave, 16 entries plus a saturated end point.
   function automatic longint beam_sine(input logic [15:0] p);
      int     tbl[17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
                          25330, 27246, 28899, 30274, 31357, 32138, 32610, 32767};
      int     off, idx, fr;
      longint mag;
      off = p[13:0];
      if (p[14]) off = 16384 - off;
      idx = off >> 10;
      fr  = off & 1023;
      if (idx >= 16) mag = tbl[16];
      else mag = tbl[idx] + (((tbl[idx+1] - tbl[idx]) * fr + 512) >>> 10);
      return p[15] ? -mag : mag;
   endfunction

   function automatic bit span_overlaps(input longint v[4], input longint off,
                                        input longint size);
      longint mn, mx, c;
      mn = v[0]; mx = v[0];
      for (int i = 1; i < 4; i++) begin
         if (v[i] < mn) mn = v[i];
         if (v[i] > mx) mx = v[i];
      end
      c = mn + mx + off;
      if (c < 0) c = -c;
      return c < (mx - mn) + size;
   endfunction

   // Two-pass separating axis test at one common scale.
   function automatic bit predict_hit(input pair_type p);
      longint S = 65536;
      longint bx, by, bw, bl, ox, oy, ow, oh, s, c, dx, dy;
      longint xs[4], ys[4], hx[2], hy[2];
      logic [15:0] t;
      bit h;
      bx = p.bx; by = p.by; bw = p.bw; bl = p.bl;
      ox = p.ox; oy = p.oy; ow = p.ow; oh = p.oh;
      t = p.ph - 16'd16384;
      s = beam_sine(t);
      c = beam_sine(t + 16'd16384);
      hx[0] = -bw; hx[1] = bw; hy[0] = 0; hy[1] = 2 * bl;
      for (int i = 0; i < 4; i++) begin
         dx = hx[i & 1]; dy = hy[i >> 1];
         xs[i] = dx * c - dy * s;
         ys[i] = dx * s + dy * c;
      end
      h = span_overlaps(xs, 2 * (bx - ox) * S, ow * S) &&
          span_overlaps(ys, 2 * (by - oy) * S, oh * S);
      if (h) begin
         hx[0] = 2 * (ox - bx) - ow; hx[1] = 2 * (ox - bx) + ow;
         hy[0] = 2 * (oy - by) - oh; hy[1] = 2 * (oy - by) + oh;
         for (int i = 0; i < 4; i++) begin
            dx = hx[i & 1]; dy = hy[i >> 1];
            xs[i] = dx * c + dy * s;
            ys[i] = dy * c - dx * s;
         end
         h = span_overlaps(xs, 0, bw * S) && span_overlaps(ys, -bl * S, bl * S);
      end
      return h;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at result %0d: %s", results_seen, what);
      errors++;
   endtask

   function automatic pair_type build_pair(input int bx, by, bw, bl, ph, ox, oy, ow, oh);
      pair_type p;
      p.bx = 16'(bx); p.by = 16'(by); p.bw = 15'(bw); p.bl = 15'(bl); p.ph = 16'(ph);
      p.ox = 16'(ox); p.oy = 16'(oy); p.ow = 15'(ow); p.oh = 15'(oh);
      return p;
   endfunction

   task automatic add_row(input pair_type p, input int h);
      dir_pair.push_back(p);
      dir_hit.push_back(h);
   endtask

   // Random pair: mostly near misses and hits around the anchor, some full range.
   function automatic pair_type random_pair();
      pair_type p;
      int       spread;
      p.ph = 16'($urandom());
      if ($urandom_range(0, 9) < 8) begin
         spread = $urandom_range(0, 1) ? 512 : 4096;
         p.bx = 16'(int'($urandom_range(0, 4095)) - 2048);
         p.by = 16'(int'($urandom_range(0, 4095)) - 2048);
         p.bw = 15'($urandom_range(0, spread));
         p.bl = 15'($urandom_range(0, spread));
         p.ox = 16'(int'(p.bx) + int'($urandom_range(0, 2 * spread)) - spread);
         p.oy = 16'(int'(p.by) + int'($urandom_range(0, 2 * spread)) - spread);
         p.ow = 15'($urandom_range(0, spread));
         p.oh = 15'($urandom_range(0, spread));
         if ($urandom_range(0, 7) == 0) p.ph = {2'($urandom_range(0, 3)), 14'd0};
      end else begin
         p.bx = 16'($urandom()); p.by = 16'($urandom());
         p.bw = 15'($urandom()); p.bl = 15'($urandom());
         p.ox = 16'($urandom()); p.oy = 16'($urandom());
         p.ow = 15'($urandom()); p.oh = 15'($urandom());
      end
      return p;
   endfunction

   // Sender: directed rows, then random pairs, over four run phases with different idle and stall shares.
   initial begin
      pair_type p;
      int       n;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      stim_done = 1'b0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Phase 0 up: upright beam hanging down from the anchor.
      add_row(build_pair(0, 0, 64, 64, 16'h4000, 0, 32, 16, 16), 1);
      // Box far away
      add_row(build_pair(0, 0, 64, 64, 16'h4000, 16000, 16000, 16, 16), 0);
      // Both zero width on x: strict test fails
      add_row(build_pair(0, 0, 0, 64, 16'h4000, 0, 32, 0, 16), 0);
      // Zero-size beam inside a box still hits
      add_row(build_pair(0, 0, 0, 0, 16'h4000, 0, 0, 16, 16), -1);
      // Touching edges in x: beam x in [-32,32], box [32,64]
      add_row(build_pair(0, 0, 64, 64, 16'h4000, 48, 32, 32, 16), 0);
      add_row(build_pair(0, 0, 64, 64, 16'h4000, 47, 32, 32, 16), 1);
      // Touching along y: beam spans 0..64 down, box 64..96
      add_row(build_pair(0, 0, 64, 64, 16'h4000, 0, 80, 16, 32), 0);
      // Every quadrant and in-between phases
      for (int q = 0; q < 8; q++)
         add_row(build_pair(100, -100, 200, 800, q * 8192, 300, 200, 100, 100), -1);
      // Extremes of the fields
      add_row(build_pair(-32768, -32768, 32767, 32767, 16'hFFFF,
                         32767, 32767, 32767, 32767), -1);
      add_row(build_pair(32767, 32767, 32767, 32767, 0,
                         -32768, -32768, 32767, 32767), -1);
      add_row(build_pair(-32768, 32767, 0, 0, 16'h8000, 32767, -32768, 0, 0), 0);
      add_row(build_pair(0, 0, 32767, 32767, 16'h2000, 0, 0, 32767, 32767), 1);
      add_row(build_pair(1234, -4321, 5, 7000, 16'h3FFF, 1234, -1000, 3, 3), -1);
      add_row(build_pair(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);

      n = 0;
      while (n < dir_pair.size() + RANDOM_ITEMS) begin
         if (n < dir_pair.size()) p = dir_pair[n];
         else p = random_pair();
         case ((n * 4) / (dir_pair.size() + RANDOM_ITEMS))
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         while ($urandom_range(0, 99) < send_idle_pct) begin
            req_tvalid = 1'b0;
            @(negedge clock);
         end
         req_tvalid = 1'b1;
         req_tdata  = pack_pair(p);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         if (n < dir_pair.size() && dir_hit[n] >= 0) begin
            if (predict_hit(p) != dir_hit[n])
               report_mismatch($sformatf("row %0d predictor disagrees with table", n));
            hit_queue.push_back(1'(dir_hit[n]));
         end else begin
            hit_queue.push_back(predict_hit(p));
         end
         requests_sent++;
         n++;
         @(negedge clock);
      end
      req_tvalid = 1'b0;
      stim_done = 1'b1;
   end

   // Receiver: random stalls at the falling edge.
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Result checking and the idle watchdog, sampled at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (hit_queue.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               if (rsp_tdata !== {7'd0, hit_queue[0]})
                  report_mismatch($sformatf("hit %h, expected %0d",
                                            rsp_tdata, hit_queue[0]));
               if (hit_queue[0]) hits_seen++;
               void'(hit_queue.pop_front());
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
      end
   end

   // End of run: drain, settle, summarize, verdict.
   initial begin
      errors = 0; requests_sent = 0; results_seen = 0; hits_seen = 0;
      timed_out = 1'b0;
      @(negedge reset);
      while (!timed_out && !(stim_done && hit_queue.size() == 0)) @(posedge clock);
      if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clock);
      if (timed_out) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("rotated_beam_box_overlap regression: fail");
      end else begin
         if (hit_queue.size() != 0) report_mismatch("requests left without a result");
         $display("covered %0d requests, %0d results (%0d hits) over four idle/stall mixes",
                  requests_sent, results_seen, hits_seen);
         if (errors == 0) $display("rotated_beam_box_overlap regression: pass");
         else $display("rotated_beam_box_overlap regression: fail");
      end
      $finish;
   end

endmodule
